@@ sv/mpo_sil_pkg.sv @@
// ----------------------------------------------------------------------------
// MPO second-image locator package
// Word types, status codes, parse phases and signatures shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package mpo_sil_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] second_offset;
		logic        little_endian;
	} out_word_t;

	typedef enum logic [2:0] {
		PH_START  = 3'd0,
		PH_SEG    = 3'd1,
		PH_SKIP   = 3'd2,
		PH_TIFF   = 3'd3,
		PH_COUNT  = 3'd4,
		PH_OFFSET = 3'd5,
		PH_HOLD   = 3'd6
	} phase_t;

	localparam logic [2:0] ST_NOT_MPO   = 3'd0;
	localparam logic [2:0] ST_SINGLE    = 3'd1;
	localparam logic [2:0] ST_SECOND    = 3'd2;
	localparam logic [2:0] ST_MALFORMED = 3'd3;
	localparam logic [2:0] ST_TRUNCATED = 3'd4;

	localparam logic [7:0] MARKER_PREFIX = 8'hFF;
	localparam logic [7:0] APP2_CODE     = 8'hE2;

	// last entry pads the table to four and is never compared
	localparam logic [0:3][7:0] START_SIG = {8'hFF, 8'hD8, 8'hFF, 8'hFF};
	localparam logic [0:3][7:0] MPF_SIG   = {8'h4D, 8'h50, 8'h46, 8'h00};
	localparam logic [0:3][7:0] II_SIG    = {8'h49, 8'h49, 8'h2A, 8'h00};

	localparam logic [31:0] COUNT_LIMIT  = 32'd16;
	localparam logic [33:0] COUNT_REL    = 34'd38;
	localparam logic [33:0] REL_MIN      = 34'd16;
	localparam logic [31:0] TIFF_HEADER  = 32'd8;
	localparam int          OFFSET_SKIP  = 36;

	// big endian shifts in; little endian drops the byte into its lane
	function automatic logic [31:0] gather(input logic [31:0] cw, input logic le,
			input logic [1:0] n, input logic [7:0] b);
		logic [31:0] r;
		begin
			if (le) begin
				case (n)
					2'd0:    r = cw | {24'h0, b};
					2'd1:    r = cw | {16'h0, b, 8'h0};
					2'd2:    r = cw | {8'h0, b, 16'h0};
					default: r = cw | {b, 24'h0};
				endcase
			end else begin
				r = {cw[23:0], b};
			end
			return r;
		end
	endfunction

endpackage

`default_nettype wire

@@ sv/mpo_second_image_locator_unit.sv @@
// ----------------------------------------------------------------------------
// MPO second-image locator
// Walks JPEG marker segments of a byte stream and reports where the second
// picture of a multi-picture file starts.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one file byte per word, end_of_stream set on the final byte.
//   out_* : at most one status word per stream; later bytes give nothing
//           until the byte flagged end_of_stream re-arms the parser.
//   A word accepted on in_* is held in the input register and is parsed
//   as it leaves it; its status word is loaded into the result register
//   as the byte leaves, and out_valid is driven from that register.
//   Throughput is one byte per cycle: parsing is a single pass of compares
//   and 32-bit adds between the input register and the result register.
//   When the receiver stalls, bytes that raise no status keep flowing; a
//   byte that raises one waits in the input register until the result
//   register frees, and in_ready drops with it.
//   Reset clears the parser to the start-marker check at position zero;
//   the final byte of each stream does the same.
// ----------------------------------------------------------------------------
`default_nettype none

module mpo_second_image_locator_unit
	import mpo_sil_pkg::*;
#(
	parameter int POSITION_BITS = 32
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_word_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_word_t      out_data
);

	localparam int PW = POSITION_BITS;

	// input register
	logic     valid_s1;
	in_word_t word_s1;

	// parse state
	logic [PW-1:0] pos_q, seg_start_q, app2_q;
	logic [15:0]   seglen_q;
	logic [31:0]   cw_q;
	logic          order_q, decided_q;
	logic [2:0]    held_q;
	phase_t        phase_q;

	logic [PW-1:0] n_pos, n_seg_start, n_app2;
	logic [15:0]   n_seglen;
	logic [31:0]   n_cw;
	logic          n_order, n_decided;
	logic [2:0]    n_held;
	phase_t        n_phase;

	logic          res_valid;
	logic [2:0]    res_status;
	logic [31:0]   res_cw;
	logic          res_order;
	logic          do_finish;
	logic [2:0]    fin_st;
	logic          fin_ok;
	logic [PW:0]   pos_inc;
	logic [PW-1:0] k, k_app, skip_target;
	logic [16:0]   nxt;
	logic [15:0]   nlen;
	logic [31:0]   g, g_cnt;
	logic [33:0]   rel;
	logic [31:0]   cw_t;
	logic [7:0]    b;
	logic          eos;
	logic          s1_adv;
	out_word_t     out_q;
	logic          out_valid_q;

	assign b   = word_s1.data_byte;
	assign eos = word_s1.end_of_stream;

	assign k           = pos_q - seg_start_q;
	assign k_app       = pos_q - app2_q;
	assign skip_target = seg_start_q + PW'(seglen_q) + PW'(2);
	assign nxt         = {1'b0, seglen_q} + 17'd2;
	assign nlen        = {seglen_q[15:8], b};
	assign pos_inc     = {1'b0, pos_q} + (PW+1)'(1);
	assign fin_ok      = pos_inc >= (PW+1)'(seglen_q);
	assign g           = gather(cw_q, order_q, k_app[1:0], b);
	assign g_cnt       = gather(cw_q, order_q, k[1:0], b);
	assign rel         = {{2{g[31]}}, g} + COUNT_REL;
	assign cw_t        = (b != II_SIG[k_app[1:0]]) ? 32'd0 : cw_q;

	// advance when no result is raised or the result register can take it
	assign s1_adv   = valid_s1 && (!res_valid || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_adv;

	always_comb begin
		n_pos       = pos_q;
		n_seg_start = seg_start_q;
		n_app2      = app2_q;
		n_seglen    = seglen_q;
		n_cw        = cw_q;
		n_order     = order_q;
		n_decided   = decided_q;
		n_held      = held_q;
		n_phase     = phase_q;
		res_valid   = 1'b0;
		res_status  = ST_NOT_MPO;
		do_finish   = 1'b0;
		fin_st      = ST_SINGLE;

		if (!decided_q) begin
			unique case (phase_q)
				PH_START: begin
					if (pos_q > PW'(2) || b != START_SIG[pos_q[1:0]]) begin
						res_valid = 1'b1;
					end else if (pos_q == PW'(2)) begin
						n_seg_start = PW'(2);
						n_phase     = PH_SEG;
					end
				end
				PH_SEG: begin
					if (k == PW'(0)) begin
						res_valid = (b != MARKER_PREFIX);
					end else if (k == PW'(1)) begin
						n_cw = {31'd0, b == APP2_CODE};
					end else if (k == PW'(2)) begin
						n_seglen = {b, 8'h00};
					end else if (k == PW'(3)) begin
						n_seglen = nlen;
						if (cw_q == 32'd0) begin
							if (nlen < 16'd2)
								res_valid = 1'b1;
							else
								n_phase = PH_SKIP;
						end
					end else if (k <= PW'(7)) begin
						if (b == MPF_SIG[k[1:0]]) begin
							if (k == PW'(7)) begin
								n_app2  = seg_start_q;
								n_phase = PH_TIFF;
								n_cw    = 32'd1;
							end
						end else if (nxt < {14'd0, k[2:0]}) begin
							res_valid = 1'b1;
						end else if (nxt == {14'd0, k[2:0]}) begin
							// next marker falls on this byte
							n_seg_start = pos_q;
							res_valid   = (b != MARKER_PREFIX);
						end else begin
							n_phase = PH_SKIP;
						end
					end
				end
				PH_SKIP: begin
					if (pos_q == skip_target) begin
						n_seg_start = pos_q;
						n_phase     = PH_SEG;
						res_valid   = (b != MARKER_PREFIX);
					end
				end
				PH_TIFF: begin
					if (k_app[PW-1:2] == (PW-2)'(2)) begin
						if (k_app[1:0] == 2'd3) begin
							n_order = cw_t[0];
							n_cw    = 32'd0;
						end else begin
							n_cw = cw_t;
						end
					end else if (k_app[PW-1:2] == (PW-2)'(3)) begin
						if (k_app[1:0] == 2'd3) begin
							n_cw = 32'd0;
							// count field would lie behind the cursor
							if (rel[33] || rel < REL_MIN) begin
								res_valid  = 1'b1;
								res_status = ST_MALFORMED;
							end else begin
								n_seg_start = app2_q + rel[PW-1:0];
								n_phase     = PH_COUNT;
							end
						end else begin
							n_cw = g;
						end
					end
				end
				PH_COUNT, PH_OFFSET: begin
					if (k[PW-1:2] == (PW-2)'(0)) begin
						n_cw = g_cnt;
						if (k[1:0] == 2'd3) begin
							if (phase_q == PH_COUNT) begin
								n_cw = 32'd0;
								if (g_cnt <= COUNT_LIMIT) begin
									do_finish = 1'b1;
									fin_st    = ST_SINGLE;
								end else begin
									n_seg_start = seg_start_q + PW'(OFFSET_SKIP);
									n_phase     = PH_OFFSET;
								end
							end else begin
								n_cw      = g_cnt + 32'(app2_q) + TIFF_HEADER;
								do_finish = 1'b1;
								fin_st    = ST_SECOND;
							end
						end
					end
				end
				PH_HOLD: begin
					do_finish = 1'b1;
					fin_st    = held_q;
				end
				default: ;
			endcase

			// hold a found status until the file is as long as the APP2 length
			if (do_finish) begin
				if (fin_ok) begin
					res_valid  = 1'b1;
					res_status = fin_st;
				end else begin
					n_held  = fin_st;
					n_phase = PH_HOLD;
				end
			end

			if (!res_valid && eos) begin
				res_valid  = 1'b1;
				res_status = ST_TRUNCATED;
			end
		end

		// take the result fields before the final byte clears the state
		res_cw    = n_cw;
		res_order = n_order;

		if (eos) begin
			n_pos       = '0;
			n_seg_start = PW'(2);
			n_app2      = '0;
			n_seglen    = '0;
			n_cw        = '0;
			n_order     = 1'b0;
			n_decided   = 1'b0;
			n_held      = ST_NOT_MPO;
			n_phase     = PH_START;
		end else begin
			n_pos     = pos_q + PW'(1);
			n_decided = decided_q | res_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			word_s1 <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			seg_start_q <= PW'(2);
			app2_q      <= '0;
			seglen_q    <= '0;
			cw_q        <= '0;
			order_q     <= 1'b0;
			decided_q   <= 1'b0;
			held_q      <= ST_NOT_MPO;
			phase_q     <= PH_START;
		end else if (s1_adv) begin
			pos_q       <= n_pos;
			seg_start_q <= n_seg_start;
			app2_q      <= n_app2;
			seglen_q    <= n_seglen;
			cw_q        <= n_cw;
			order_q     <= n_order;
			decided_q   <= n_decided;
			held_q      <= n_held;
			phase_q     <= n_phase;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && res_valid) begin
			out_q.status        <= res_status;
			out_q.second_offset <= (res_status == ST_SECOND) ? res_cw : 32'd0;
			out_q.little_endian <= res_order;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_eos_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && eos) |=> (phase_q == PH_START && pos_q == '0 && !decided_q))
		else $error("parser not re-armed after final byte");

	a_hold_status: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HOLD) |-> (held_q == ST_SINGLE || held_q == ST_SECOND))
		else $error("held status is neither single nor second image");

	a_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status != ST_SECOND) |-> (out_q.second_offset == 32'd0))
		else $error("offset set on a status other than second image");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && res_valid && out_valid_q && !out_ready))
		else $error("input stalled without a blocked result");
`endif

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// MPO second-image locator testbench
// Feeds whole byte streams through the locator: directed start, marker-walk,
// MPF header and hold cases, then random well-formed, cut and broken streams.
// A local copy of the parser predicts each status word at input accept, and
// a checker compares every output word with the oldest prediction. Both
// sides idle at random per word unless set calm.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import mpo_sil_pkg::*;

	localparam int CYCLE_LIMIT = 500000;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_data;

	// predicted parser state
	logic [31:0] p_pos;
	logic [31:0] p_base;
	logic [15:0] p_len;
	logic [31:0] p_app2;
	logic [31:0] p_ifd;
	logic [31:0] p_word;
	logic        p_le;
	logic        p_done;
	logic [2:0]  p_held;
	phase_t      p_phase;

	out_word_t   pending_status[$];
	logic [7:0]  file_bytes[$];
	int          err_count = 0;
	int          sent_bytes = 0;
	int          cycle_count;
	bit          calm_in = 1'b0;
	bit          calm_out = 1'b0;

	mpo_second_image_locator_unit #(
		.POSITION_BITS(32)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Status prediction
	// ------------------------------------------------------------------------
	function automatic void clear_locator();
		p_pos   = 32'd0;
		p_phase = PH_START;
		p_base  = 32'd2;
		p_len   = 16'd0;
		p_app2  = 32'd0;
		p_ifd   = 32'd0;
		p_le    = 1'b0;
		p_word  = 32'd0;
		p_done  = 1'b0;
		p_held  = ST_NOT_MPO;
	endfunction

	function automatic void lane_gather(input logic [1:0] n, input logic [7:0] b);
		if (p_le)
			p_word = p_word | ({24'd0, b} << (8 * n));
		else
			p_word = {p_word[23:0], b};
	endfunction

	// hold a decided status until the APP2 segment length has been received
	function automatic int release_status(input logic [2:0] st);
		if ({1'b0, p_pos} + 33'd1 >= {17'd0, p_len})
			return int'(st);
		p_held  = st;
		p_phase = PH_HOLD;
		return -1;
	endfunction

	function automatic int walk_segment(input logic [7:0] b);
		logic [31:0] k;
		logic [31:0] nxt;
		k = p_pos - p_base;
		if (k == 32'd0)
			return (b == MARKER_PREFIX) ? -1 : int'(ST_NOT_MPO);
		if (k == 32'd1) begin
			p_word = (b == APP2_CODE) ? 32'd1 : 32'd0;
		end else if (k == 32'd2) begin
			p_len = {b, 8'h00};
		end else if (k == 32'd3) begin
			p_len = p_len | {8'h00, b};
			if (p_word == 32'd0) begin
				if (p_len < 16'd2)
					return int'(ST_NOT_MPO);
				p_phase = PH_SKIP;
			end
		end else if (k <= 32'd7) begin
			if (b == MPF_SIG[k[1:0]]) begin
				if (k == 32'd7) begin
					p_app2  = p_base;
					p_phase = PH_TIFF;
					p_word  = 32'd1;
				end
			end else begin
				// a short APP2 may put the next marker inside the MPF check
				nxt = {16'd0, p_len} + 32'd2;
				if (nxt < k)
					return int'(ST_NOT_MPO);
				if (nxt == k) begin
					p_base = p_pos;
					return (b == MARKER_PREFIX) ? -1 : int'(ST_NOT_MPO);
				end
				p_phase = PH_SKIP;
			end
		end
		return -1;
	endfunction

	function automatic int parse_byte(input logic [7:0] b);
		logic [31:0] k;
		logic [31:0] n;
		longint      rel;
		case (p_phase)
			PH_START: begin
				if (p_pos > 32'd2 || b != START_SIG[p_pos[1:0]])
					return int'(ST_NOT_MPO);
				if (p_pos == 32'd2) begin
					p_base  = 32'd2;
					p_phase = PH_SEG;
				end
				return -1;
			end
			PH_SEG: return walk_segment(b);
			PH_SKIP: begin
				if (p_pos == p_base + {16'd0, p_len} + 32'd2) begin
					p_base  = p_pos;
					p_phase = PH_SEG;
					return walk_segment(b);
				end
				return -1;
			end
			PH_TIFF: begin
				k = p_pos - p_app2;
				if (k >= 32'd8 && k <= 32'd11) begin
					if (b != II_SIG[k[1:0]])
						p_word = 32'd0;
					if (k == 32'd11) begin
						p_le   = p_word[0];
						p_word = 32'd0;
					end
				end else if (k >= 32'd12 && k <= 32'd15) begin
					lane_gather(k[1:0], b);
					if (k == 32'd15) begin
						p_ifd  = p_word;
						p_word = 32'd0;
						rel    = longint'($signed(p_ifd)) + 38;
						if (rel < 16)
							return int'(ST_MALFORMED);
						p_base  = p_app2 + rel[31:0];
						p_phase = PH_COUNT;
					end
				end
				return -1;
			end
			PH_COUNT, PH_OFFSET: begin
				n = p_pos - p_base;
				if (n < 32'd4) begin
					lane_gather(n[1:0], b);
					if (n == 32'd3) begin
						if (p_phase == PH_COUNT) begin
							if (p_word <= 32'd16) begin
								p_word = 32'd0;
								return release_status(ST_SINGLE);
							end
							p_word  = 32'd0;
							p_base  = p_base + 32'd36;
							p_phase = PH_OFFSET;
						end else begin
							p_word = p_word + p_app2 + 32'd8;
							return release_status(ST_SECOND);
						end
					end
				end
				return -1;
			end
			PH_HOLD: return release_status(p_held);
			default: return -1;
		endcase
	endfunction

	function automatic void locate_step(input logic [7:0] b, input logic eos);
		int        st;
		out_word_t r;
		st = -1;
		if (!p_done)
			st = parse_byte(b);
		if (st < 0 && eos && !p_done)
			st = int'(ST_TRUNCATED);
		if (st >= 0) begin
			r.status        = st[2:0];
			r.second_offset = (st == ST_SECOND) ? p_word : 32'd0;
			r.little_endian = p_le;
			pending_status.push_back(r);
		end
		if (eos) begin
			clear_locator();
		end else begin
			p_pos = p_pos + 32'd1;
			if (st >= 0)
				p_done = 1'b1;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Stream building
	// ------------------------------------------------------------------------
	function automatic void put_byte(input logic [7:0] b);
		file_bytes.push_back(b);
	endfunction

	function automatic void put_word32(input logic [31:0] v, input logic le);
		for (int i = 0; i < 4; i++)
			put_byte(le ? v[8 * i +: 8] : v[31 - 8 * i -: 8]);
	endfunction

	function automatic void pad_to(input int n);
		while (file_bytes.size() < n)
			put_byte(8'($urandom));
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0, 1:    return MARKER_PREFIX;
			2:       return 8'hD8;
			3:       return APP2_CODE;
			4:       return MPF_SIG[0];
			5:       return MPF_SIG[1];
			6:       return MPF_SIG[2];
			7:       return 8'h00;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic void put_segment(input logic [7:0] marker, input logic [15:0] len);
		put_byte(MARKER_PREFIX);
		put_byte(marker);
		put_byte(len[15:8]);
		put_byte(len[7:0]);
		repeat (int'(len) - 2)
			put_byte(8'($urandom));
	endfunction

	// SOI plus a few segments that the walk must skip
	function automatic void start_file(input int pre);
		logic [7:0] marker;
		file_bytes = {8'hFF, 8'hD8};
		repeat (pre) begin
			marker = 8'($urandom);
			if ($urandom_range(0, 3) == 0)
				marker = APP2_CODE;
			else if (marker == APP2_CODE)
				marker = 8'hE1;
			put_segment(marker, 16'($urandom_range(2, 10)));
		end
	endfunction

	function automatic void append_mpf(input logic le, input logic tiff_ok,
			input logic [31:0] ifd, input logic [31:0] count, input logic [31:0] off,
			input logic [15:0] len, input int tail);
		int     a;
		logic   le_eff;
		longint rel;
		a      = file_bytes.size();
		le_eff = le && tiff_ok;
		put_byte(MARKER_PREFIX);
		put_byte(APP2_CODE);
		put_byte(len[15:8]);
		put_byte(len[7:0]);
		for (int i = 0; i < 4; i++)
			put_byte(MPF_SIG[i]);
		if (le) begin
			put_word32(32'h49492A00, 1'b0);
		end else begin
			put_word32(32'h4D4D002A, 1'b0);
		end
		if (!tiff_ok)
			file_bytes[a + 8 + $urandom_range(0, 3)] ^= 8'h01;
		put_word32(ifd, le_eff);
		rel = longint'($signed(ifd)) + 38;
		// only lay out count and offset when they fall a short way ahead
		if (rel >= 16 && rel <= 400) begin
			pad_to(a + int'(rel));
			put_word32(count, le_eff);
			pad_to(a + int'(rel) + 36);
			put_word32(off, le_eff);
		end
		repeat (tail)
			put_byte(8'($urandom));
	endfunction

	// ------------------------------------------------------------------------
	// Driving and checking
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (err_count < 200)
			$display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
		err_count++;
	endtask

	task automatic send_word(input logic [7:0] b, input logic eos);
		int gap;
		gap = calm_in ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= {b, eos};
		do @(posedge clk); while (!in_ready);
		sent_bytes++;
		locate_step(b, eos);
	endtask

	task automatic send_file();
		int last;
		last = file_bytes.size() - 1;
		for (int i = 0; i <= last; i++)
			send_word(file_bytes[i], i == last);
		file_bytes.delete();
	endtask

	task automatic wait_status_drained();
		in_valid <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin : status_check
		out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_status.size() == 0) begin
				report_mismatch("unexpected status word", {29'd0, out_data.status}, 32'd0);
			end else begin
				want = pending_status.pop_front();
				if (out_data.status !== want.status)
					report_mismatch("status", {29'd0, out_data.status},
						{29'd0, want.status});
				if (out_data.second_offset !== want.second_offset)
					report_mismatch("second_offset", out_data.second_offset,
						want.second_offset);
				if (out_data.little_endian !== want.little_endian)
					report_mismatch("little_endian", {31'd0, out_data.little_endian},
						{31'd0, want.little_endian});
			end
		end
	end

	// receiver: outside calm mode, stall each status word a random number of cycles
	initial begin : status_sink
		int gap;
		out_ready <= 1'b0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (calm_out) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else begin
				out_ready <= 1'b0;
				do @(posedge clk); while (!out_valid);
				gap = $urandom_range(0, 14);
				repeat (gap) @(posedge clk);
				out_ready <= 1'b1;
				do @(posedge clk); while (!(out_valid && out_ready));
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench NOT OK");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	task automatic test_start_check();
		calm_in  = 1'b1;
		calm_out = 1'b1;
		file_bytes = {8'h00, 8'h11, 8'h22};
		send_file();
		file_bytes = {8'hFF, 8'h00};
		send_file();
		file_bytes = {8'hFF, 8'hD8, 8'h00};
		send_file();
		file_bytes = {8'hFF};
		send_file();
		file_bytes = {8'hFF, 8'hD8, 8'hFF};
		send_file();
	endtask

	task automatic test_segment_walk();
		calm_in  = 1'b0;
		calm_out = 1'b0;
		// marker that does not begin with FF
		file_bytes = {8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h04, 8'hAA, 8'hBB, 8'h12};
		send_file();
		// lengths below two
		file_bytes = {8'hFF, 8'hD8, 8'hFF, 8'hC4, 8'h00, 8'h01};
		send_file();
		file_bytes = {8'hFF, 8'hD8, 8'hFF, 8'hDB, 8'h00, 8'h00};
		send_file();
		// next marker lands on the first MPF byte
		file_bytes = {8'hFF, 8'hD8, 8'hFF, 8'hE2, 8'h00, 8'h02};
		append_mpf(1'b0, 1'b1, 32'd8, 32'd2, 32'd0, 16'd10, 2);
		send_file();
		// next marker lands on the second MPF byte after a match
		file_bytes = {8'hFF, 8'hD8, 8'hFF, 8'hE2, 8'h00, 8'h03, 8'h4D};
		append_mpf(1'b1, 1'b1, 32'd8, 32'd17, 32'h1234, 16'd0, 0);
		send_file();
		// next marker would already lie behind the cursor
		file_bytes = {8'hFF, 8'hD8, 8'hFF, 8'hE2, 8'h00, 8'h02, 8'h4D, 8'h51};
		send_file();
		// APP2 without MPF skipped by its length
		file_bytes = {8'hFF, 8'hD8, 8'hFF, 8'hE2, 8'h00, 8'h08, 8'h4D, 8'h50,
			8'h00, 8'h00, 8'h11, 8'h22};
		append_mpf(1'b1, 1'b1, 32'hFFFF_FFEA, 32'd40, 32'h0BAD_F00D, 16'd0, 1);
		send_file();
	endtask

	task automatic test_mpf_fields();
		calm_out = 1'b1;
		start_file(0);
		append_mpf(1'b1, 1'b1, 32'd8, 32'd17, 32'h100, 16'd0, 3);
		send_file();
		start_file(1);
		append_mpf(1'b0, 1'b1, 32'd8, 32'd16, $urandom, 16'd0, 2);
		send_file();
		// offset sum wraps
		start_file(0);
		append_mpf(1'b1, 1'b1, 32'hFFFF_FFEA, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 0);
		send_file();
		calm_out = 1'b0;
		// IFD behind the cursor
		start_file(0);
		append_mpf(1'b0, 1'b1, 32'hFFFF_FFE9, 32'd20, 32'd0, 16'd0, 4);
		send_file();
		start_file(0);
		append_mpf(1'b1, 1'b1, 32'h8000_0000, 32'd20, 32'd0, 16'd0, 4);
		send_file();
		// damaged II header falls back to big endian
		start_file(0);
		append_mpf(1'b1, 1'b0, 32'd8, 32'd17, 32'hABCD, 16'd0, 1);
		send_file();
		// target far ahead is never met
		start_file(0);
		append_mpf(1'b0, 1'b1, 32'h7FFF_FFFF, 32'd0, 32'd0, 16'd0, 5);
		send_file();
	endtask

	task automatic test_hold_release();
		calm_in = 1'b0;
		start_file(0);
		append_mpf(1'b1, 1'b1, 32'd8, 32'd17, 32'h55, 16'd150, 0);
		pad_to(160);
		send_file();
		start_file(0);
		append_mpf(1'b0, 1'b1, 32'd8, 32'd3, 32'd0, 16'hFFFF, 10);
		send_file();
	endtask

	task automatic test_random_streams();
		int          streams;
		int          kind;
		int          cut;
		int          lo;
		int          r;
		logic [31:0] ifd;
		logic [31:0] count;
		logic [15:0] len;
		streams = 0;
		while (sent_bytes < 1300) begin
			calm_in  = ($urandom_range(0, 4) == 0);
			calm_out = ($urandom_range(0, 4) == 0);
			kind     = $urandom_range(0, 9);
			if (kind <= 4) begin
				r = $urandom_range(0, 19);
				if (r == 0)
					ifd = $urandom;
				else if (r == 1)
					ifd = 32'd0 - 32'($urandom_range(23, 40));
				else
					ifd = 32'($urandom_range(0, 46)) - 32'd22;
				if ($urandom_range(0, 1) == 0)
					count = 32'($urandom_range(0, 16));
				else if ($urandom_range(0, 3) == 0)
					count = $urandom;
				else
					count = 32'($urandom_range(17, 40));
				r = $urandom_range(0, 9);
				if (r == 0)
					len = 16'($urandom);
				else if (r <= 2)
					len = 16'($urandom_range(100, 200));
				else
					len = 16'($urandom_range(0, 120));
				start_file($urandom_range(0, 2));
				append_mpf(1'($urandom_range(0, 1)), $urandom_range(0, 7) != 0, ifd,
					count, $urandom, len,
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 100) :
						$urandom_range(0, 6));
				if (kind == 4) begin
					cut = $urandom_range(1, file_bytes.size());
					while (file_bytes.size() > cut)
						void'(file_bytes.pop_back());
				end
			end else if (kind <= 6) begin
				file_bytes.delete();
				if ($urandom_range(0, 1) == 0)
					file_bytes = {8'hFF, 8'hD8, 8'hFF};
				repeat ($urandom_range(1, 12))
					put_byte(pick_byte());
			end else if (kind <= 8) begin
				file_bytes = {8'hFF, 8'hD8};
				repeat ($urandom_range(1, 4)) begin
					put_byte(($urandom_range(0, 5) == 0) ? pick_byte() : MARKER_PREFIX);
					put_byte(pick_byte());
					put_byte(($urandom_range(0, 9) == 0) ? pick_byte() : 8'h00);
					lo = $urandom_range(0, 12);
					put_byte(8'(lo));
					if (lo > 2)
						repeat (lo - 2)
							put_byte(pick_byte());
				end
				repeat ($urandom_range(0, 6))
					put_byte(pick_byte());
			end else begin
				// short APP2 around the MPF check
				file_bytes = {8'hFF, 8'hD8, 8'hFF, APP2_CODE, 8'h00,
					8'($urandom_range(0, 8))};
				for (int i = 0; i < 4; i++) begin
					r = $urandom_range(0, 3);
					put_byte((r < 2) ? MPF_SIG[i] : ((r == 2) ? MARKER_PREFIX :
						8'($urandom)));
				end
				repeat ($urandom_range(0, 6))
					put_byte(pick_byte());
			end
			send_file();
			streams++;
			if (streams == 1)
				wait_status_drained();
		end
	endtask

	initial begin
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		in_data  <= '0;
		clear_locator();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_start_check();
		test_segment_walk();
		test_mpf_fields();
		test_hold_release();
		test_random_streams();
		wait_status_drained();
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
sv/mpo_sil_pkg.sv
sv/mpo_second_image_locator_unit.sv
tb/testbench.sv
